// ----- rtl/rbqp_pkg.sv -----
// Package for the residual bucket quantize and pack unit.
// Holds register index codes and fixed field widths; no dependencies.
package rbqp_pkg;

  localparam int CUTOFF_W    = 16;
  localparam int NUM_CUTOFFS = 15;
  localparam int MEAN_W      = 16;
  localparam int ROW_LEN_W   = 13;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int CODE_W      = 4;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_MEAN      = 3'd1,
    REG_ROW_LEN   = 3'd2,
    REG_CUT_LOW   = 3'd3,
    REG_CUT_MID   = 3'd4,
    REG_CUT_UPPER = 3'd5,
    REG_CUT_TOP   = 3'd6
  } reg_idx_t;

endpackage

// ----- rtl/residual_bucket_quantize_pack_unit.sv -----
// Residual bucket quantizer with bit packing: top level.
// Depends on rbqp_pkg for register codes and field widths.
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------
// in       | sink      | in_valid/in_stall  | in_residual_sample
// out      | source    | out_valid/out_stall| out_packed_byte, out_last_of_row
// cfg      | APB slave | psel/penable/pready| paddr, pwdata, prdata (64-bit)
//
// One transaction per cycle sustained while the input stage is not stalled.
// The throughput is set by the single compare-and-insert stage between the input
// register and the output register. Reset (rst_n low, synchronous) clears the row
// state and loads register defaults. A stalled output blocks the input stage only
// when the item waiting there produces a byte.
module residual_bucket_quantize_pack_unit #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      in_residual_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_packed_byte,
  output logic                               out_last_of_row,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rbqp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rbqp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rbqp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import rbqp_pkg::*;

  localparam int DW    = ((SAMPLE_BITS > MEAN_W) ? SAMPLE_BITS : MEAN_W) + 1;
  localparam int LW    = $clog2(MAX_ROW_LENGTH + 1);
  localparam int RLW   = (LW > ROW_LEN_W) ? LW : ROW_LEN_W;
  localparam int IW    = $clog2(MAX_ROW_LENGTH);

  logic                     mode_r;
  logic [MEAN_W-1:0]        mean_r;
  logic [ROW_LEN_W-1:0]     row_len_r;
  logic [3:0][63:0]         cut_r;

  logic                     s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0]   s1_sample_r;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [7:0]               acc_r, acc_nxt;
  logic [2:0]               fill_r, fill_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r;
  logic                     out_last_r;

  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;
  logic                     clear_row;
  logic signed [DW-1:0]     diff;
  logic [NUM_CUTOFFS-1:0]   gt;
  logic [CODE_W-1:0]        bucket;
  logic [CODE_W-1:0]        ncut;
  logic [3:0]               nbits;
  logic [3:0]               fill_sum;
  logic [7:0]               acc_ins;
  logic [2:0]               pos;
  logic [RLW-1:0]           eff_len;
  logic [RLW-1:0]           idx_inc;
  logic                     row_end;
  logic                     full;
  logic                     produce;
  logic                     adv;
  logic                     in_accept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign clear_row = cfg_wr && ((cfg_idx == REG_MODE) || (cfg_idx == REG_ROW_LEN));

  always_comb begin
    case (cfg_idx)
      REG_MODE:      prdata = {{(CFG_DATA_W-1){1'b0}}, mode_r};
      REG_MEAN:      prdata = {{(CFG_DATA_W-MEAN_W){1'b0}}, mean_r};
      REG_ROW_LEN:   prdata = {{(CFG_DATA_W-ROW_LEN_W){1'b0}}, row_len_r};
      REG_CUT_LOW:   prdata = cut_r[0];
      REG_CUT_MID:   prdata = cut_r[1];
      REG_CUT_UPPER: prdata = cut_r[2];
      REG_CUT_TOP:   prdata = cut_r[3];
      default:       prdata = '0;
    endcase
  end

  // bucket search
  always_comb begin
    logic signed [DW-1:0] cut_ext;
    diff = $signed({{(DW-SAMPLE_BITS){s1_sample_r[SAMPLE_BITS-1]}}, s1_sample_r})
         - $signed({{(DW-MEAN_W){mean_r[MEAN_W-1]}}, mean_r});
    for (int k = 0; k < NUM_CUTOFFS; k++) begin
      cut_ext = $signed({{(DW-CUTOFF_W){cut_r[k/4][(k%4)*CUTOFF_W+CUTOFF_W-1]}},
                         cut_r[k/4][(k%4)*CUTOFF_W +: CUTOFF_W]});
      gt[k] = diff > cut_ext;
    end
    ncut   = mode_r ? CODE_W'(NUM_CUTOFFS) : CODE_W'(3);
    nbits  = mode_r ? 4'd4 : 4'd2;
    bucket = ncut;
    for (int k = NUM_CUTOFFS - 1; k >= 0; k--) begin
      if ((CODE_W'(k) < ncut) && !gt[k]) begin
        bucket = CODE_W'(k);
      end
    end
  end

  // bit insert and row tracking
  always_comb begin
    acc_ins = acc_r;
    pos     = '0;
    for (int b = 0; b < CODE_W; b++) begin
      pos = ~(fill_r + 3'(b));
      if (4'(b) < nbits) begin
        acc_ins[pos] = acc_ins[pos] | bucket[b];
      end
    end
    fill_sum = {1'b0, fill_r} + nbits;
    full     = fill_sum[3];

    if (row_len_r == '0) begin
      eff_len = RLW'(1);
    end else if (RLW'(row_len_r) > RLW'(MAX_ROW_LENGTH)) begin
      eff_len = RLW'(MAX_ROW_LENGTH);
    end else begin
      eff_len = RLW'(row_len_r);
    end
    idx_inc = RLW'(idx_r) + RLW'(1);
    row_end = idx_inc >= eff_len;
    produce = full || row_end;
  end

  assign adv       = s1_valid_r && (!produce || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = (adv && produce) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    if (adv) begin
      idx_nxt  = row_end ? '0 : IW'(idx_inc);
      acc_nxt  = produce ? '0 : acc_ins;
      fill_nxt = produce ? '0 : fill_sum[2:0];
    end
    if (clear_row) begin
      idx_nxt  = '0;
      acc_nxt  = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      mean_r      <= '0;
      row_len_r   <= ROW_LEN_W'(128);
      cut_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      acc_r       <= '0;
      fill_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_MODE:      mode_r    <= pwdata[0];
          REG_MEAN:      mean_r    <= pwdata[MEAN_W-1:0];
          REG_ROW_LEN:   row_len_r <= pwdata[ROW_LEN_W-1:0];
          REG_CUT_LOW:   cut_r[0]  <= pwdata;
          REG_CUT_MID:   cut_r[1]  <= pwdata;
          REG_CUT_UPPER: cut_r[2]  <= pwdata;
          REG_CUT_TOP:   cut_r[3]  <= {16'h0000, pwdata[47:0]};
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_residual_sample;
    end
    if (adv && produce) begin
      out_byte_r <= acc_ins;
      out_last_r <= row_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;
  assign out_last_of_row = out_last_r;

endmodule

// ----- rtl/rbqp_checker.sv -----
// Port-level checks for the residual bucket quantize and pack unit.
// Bound to residual_bucket_quantize_pack_unit; no package dependency.
module rbqp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_packed_byte,
  input logic       out_last_of_row
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && rst_n, 2))
    else $error("result without an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_packed_byte)
                                  && $stable(out_last_of_row)))
    else $error("stalled output changed");

endmodule

bind residual_bucket_quantize_pack_unit rbqp_checker u_rbqp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_packed_byte (out_packed_byte),
  .out_last_of_row (out_last_of_row)
);
